@@ rtl/hms_pkg.sv @@
package hms_pkg;

    // Sequencer states of the sort engine.
    typedef enum logic [4:0] {
        ST_LOAD,
        ST_INS_START,
        ST_INS_READ,
        ST_INS_CMP,
        ST_INS_SHIFT_RD,
        ST_INS_SHIFT_WR,
        ST_INS_PLACE,
        ST_MRG_START,
        ST_MRG_CHK_RD,
        ST_MRG_CHK,
        ST_MRG_COPY_RD,
        ST_MRG_COPY_WR,
        ST_MRG_RD,
        ST_MRG_SEL,
        ST_MRG_TAIL_RD,
        ST_MRG_TAIL_WR,
        ST_MRG_NEXT,
        ST_OUT_RD,
        ST_OUT_WAIT,
        ST_OUT_HOLD
    } hms_state_t;

    // Configuration register indexes.
    localparam logic REG_SIGNED_COMPARE = 1'b0;
    localparam logic REG_DESCENDING     = 1'b1;

endpackage

@@ rtl/hms_compare.sv @@
// Shared key comparator: lt is high when a orders strictly before b.
module hms_compare #(
    parameter int ELEMENT_BITS = 32
) (
    input  logic [ELEMENT_BITS-1:0] a,
    input  logic [ELEMENT_BITS-1:0] b,
    input  logic                    signed_compare,
    input  logic                    descending,
    output logic                    lt
);
    logic [ELEMENT_BITS-1:0] x;
    logic [ELEMENT_BITS-1:0] y;
    logic [ELEMENT_BITS-1:0] sign_bit;

    // Bias the sign bit for two's complement, then swap for descending order.
    always_comb
    begin
        sign_bit = '0;
        sign_bit[ELEMENT_BITS-1] = signed_compare;
        x = descending ? (b ^ sign_bit) : (a ^ sign_bit);
        y = descending ? (a ^ sign_bit) : (b ^ sign_bit);
        lt = (x < y);
    end
endmodule

@@ rtl/hybrid_merge_sorter_unit.sv @@
// Channel | Direction | Valid / Stall         | Words
// in      | input     | in_valid / in_stall   | key, last_in
// out     | output    | out_valid / out_stall | sorted_key, last_out, overflow
// cfg     | input     | cfg_we (no stall)     | cfg_index, cfg_data
//
// A key is stored, or dropped and flagged as overflow once the store is full. A
// key with last_in starts the sort: binary insertion of each run, then bottom-up
// merges, all through one comparator and one store read port. Output then
// follows. No clearing pass follows reset. A stall on a pending output word
// holds the next word back; in_stall is high whenever the engine is not loading
// keys.
module hybrid_merge_sorter_unit #(
    parameter int CAPACITY     = 64,
    parameter int ELEMENT_BITS = 32,
    parameter int RUN_LENGTH   = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] key,
    input  logic        last_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] sorted_key,
    output logic        last_out,
    output logic        overflow,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic        cfg_data
);
    localparam int HALF_CAP = (CAPACITY + 1) / 2;
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int BW = (HALF_CAP > 1) ? $clog2(HALF_CAP) : 1;
    localparam int MW = CW + 1;

    typedef logic [ELEMENT_BITS-1:0] elem_t;

    // Storage.
    elem_t store_mem [CAPACITY];
    elem_t buf_mem   [HALF_CAP];
    elem_t store_rd_reg;
    elem_t buf_rd_reg;

    hms_pkg::hms_state_t state_reg, state_next;
    logic          sgn_reg, desc_reg;
    logic [CW-1:0] count_reg, count_next;
    logic          drop_reg, drop_next;

    // Sequencer working registers, wide enough for run arithmetic.
    logic [MW-1:0] i_reg, i_next;
    logic [MW-1:0] lo_reg, lo_next;
    logic [MW-1:0] hi_reg, hi_next;
    logic [MW-1:0] j_reg, j_next;
    logic [MW-1:0] k_reg, k_next;
    logic [MW-1:0] off_reg, off_next;
    logic [MW-1:0] end_reg, end_next;
    logic [MW-1:0] mb_reg, mb_next;
    logic [MW-1:0] mid_reg, mid_next;
    logic [MW-1:0] bi_reg, bi_next;
    logic [MW-1:0] l1_reg, l1_next;
    elem_t         t_reg, t_next;
    logic          back_reg, back_next;
    logic          phase_reg, phase_next;

    logic          out_valid_reg, out_valid_next;
    logic [31:0]   out_key_reg, out_key_next;
    logic          out_last_reg, out_last_next;
    logic          out_ovf_reg, out_ovf_next;

    // Memory port controls.
    logic          st_we;
    logic [AW-1:0] st_wa, st_ra;
    elem_t         st_wd;
    logic          bf_we;
    logic [BW-1:0] bf_wa, bf_ra;
    elem_t         bf_wd;

    logic          cmp_lt;
    elem_t         cmp_a, cmp_b;

    hms_compare #(.ELEMENT_BITS(ELEMENT_BITS)) u_cmp (
        .a              (cmp_a),
        .b              (cmp_b),
        .signed_compare (sgn_reg),
        .descending     (desc_reg),
        .lt             (cmp_lt)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sgn_reg  <= 1'b0;
            desc_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hms_pkg::REG_SIGNED_COMPARE: sgn_reg  <= cfg_data;
                hms_pkg::REG_DESCENDING:     desc_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Memories with registered reads.
    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            store_mem[st_wa] <= st_wd;
        end
        store_rd_reg <= store_mem[st_ra];
        if (bf_we)
        begin
            buf_mem[bf_wa] <= bf_wd;
        end
        buf_rd_reg <= buf_mem[bf_ra];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hms_pkg::ST_LOAD;
            count_reg     <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        i_reg <= i_next;   lo_reg <= lo_next;   hi_reg <= hi_next;
        j_reg <= j_next;   k_reg <= k_next;     off_reg <= off_next;
        end_reg <= end_next; mb_reg <= mb_next; mid_reg <= mid_next;
        bi_reg <= bi_next; l1_reg <= l1_next;   t_reg <= t_next;
        back_reg <= back_next; phase_reg <= phase_next;
        out_key_reg <= out_key_next; out_last_reg <= out_last_next;
        out_ovf_reg <= out_ovf_next;
    end

    logic in_acc;
    assign in_acc   = in_valid && !in_stall;
    assign in_stall = (state_reg != hms_pkg::ST_LOAD);

    // Sequencer.
    always_comb
    begin
        logic [MW-1:0] run_end;
        logic [MW-1:0] l2;
        logic [MW-1:0] cnt_w;
        run_end = '0;
        l2 = '0;
        cnt_w = MW'(count_reg);
        state_next = state_reg;
        count_next = count_reg;
        drop_next = drop_reg;
        i_next = i_reg;   lo_next = lo_reg;   hi_next = hi_reg;
        j_next = j_reg;   k_next = k_reg;     off_next = off_reg;
        end_next = end_reg; mb_next = mb_reg; mid_next = mid_reg;
        bi_next = bi_reg; l1_next = l1_reg;   t_next = t_reg;
        back_next = back_reg; phase_next = phase_reg;
        out_valid_next = out_valid_reg;
        out_key_next = out_key_reg;
        out_last_next = out_last_reg;
        out_ovf_next = out_ovf_reg;
        st_we = 1'b0; st_wa = '0; st_wd = '0; st_ra = '0;
        bf_we = 1'b0; bf_wa = '0; bf_wd = '0; bf_ra = '0;
        cmp_a = t_reg;
        cmp_b = store_rd_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            // Collect keys.
            hms_pkg::ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (cnt_w < MW'(CAPACITY))
                    begin
                        st_we = 1'b1;
                        st_wa = AW'(count_reg);
                        st_wd = elem_t'(key);
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (last_in)
                    begin
                        off_next = '0;
                        state_next = hms_pkg::ST_INS_START;
                    end
                end
            end
            // Begin one run: i is the key being inserted.
            hms_pkg::ST_INS_START:
            begin
                if (off_reg >= cnt_w)
                begin
                    mb_next = MW'(RUN_LENGTH);
                    state_next = hms_pkg::ST_MRG_START;
                end
                else
                begin
                    run_end = off_reg + MW'(RUN_LENGTH);
                    end_next = (run_end > cnt_w) ? cnt_w : run_end;
                    i_next = off_reg + 1'b1;
                    state_next = hms_pkg::ST_INS_READ;
                end
            end
            hms_pkg::ST_INS_READ:
            begin
                if (i_reg >= end_reg)
                begin
                    off_next = end_reg;
                    state_next = hms_pkg::ST_INS_START;
                end
                else
                begin
                    st_ra = AW'(i_reg);
                    lo_next = off_reg;
                    hi_next = i_reg;
                    phase_next = 1'b0;
                    mid_next = '0;
                    back_next = 1'b0;
                    state_next = hms_pkg::ST_INS_CMP;
                end
            end
            // Binary search: phase 0 captures t on entry and issues the read of mid; phase 1 compares.
            hms_pkg::ST_INS_CMP:
            begin
                if (!phase_reg && lo_reg == off_reg && hi_reg == i_reg
                    && mid_reg != MW'(CAPACITY) && !back_reg)
                begin
                    t_next = store_rd_reg;
                    back_next = 1'b1;
                end
                if (!phase_reg)
                begin
                    if (lo_reg < hi_reg)
                    begin
                        mid_next = lo_reg + ((hi_reg - lo_reg) >> 1);
                        st_ra = AW'(lo_reg + ((hi_reg - lo_reg) >> 1));
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        j_next = i_reg;
                        back_next = 1'b0;
                        state_next = hms_pkg::ST_INS_SHIFT_RD;
                    end
                end
                else
                begin
                    phase_next = 1'b0;
                    mid_next = MW'(CAPACITY);
                    if (cmp_lt)
                    begin
                        hi_next = mid_reg;
                    end
                    else
                    begin
                        lo_next = mid_reg + 1'b1;
                    end
                end
            end
            hms_pkg::ST_INS_SHIFT_RD:
            begin
                if (j_reg > lo_reg)
                begin
                    st_ra = AW'(j_reg - 1'b1);
                    state_next = hms_pkg::ST_INS_SHIFT_WR;
                end
                else
                begin
                    state_next = hms_pkg::ST_INS_PLACE;
                end
            end
            hms_pkg::ST_INS_SHIFT_WR:
            begin
                st_we = 1'b1;
                st_wa = AW'(j_reg);
                st_wd = store_rd_reg;
                j_next = j_reg - 1'b1;
                state_next = hms_pkg::ST_INS_SHIFT_RD;
            end
            hms_pkg::ST_INS_PLACE:
            begin
                st_we = 1'b1;
                st_wa = AW'(lo_reg);
                st_wd = t_reg;
                i_next = i_reg + 1'b1;
                mid_next = '0;
                state_next = hms_pkg::ST_INS_READ;
            end
            // Merge pass over pairs of runs of size mb.
            hms_pkg::ST_MRG_START:
            begin
                if (mb_reg >= cnt_w)
                begin
                    k_next = '0;
                    state_next = hms_pkg::ST_OUT_RD;
                end
                else
                begin
                    off_next = '0;
                    state_next = hms_pkg::ST_MRG_NEXT;
                end
            end
            hms_pkg::ST_MRG_NEXT:
            begin
                if (off_reg + mb_reg >= cnt_w)
                begin
                    mb_next = mb_reg << 1;
                    state_next = hms_pkg::ST_MRG_START;
                end
                else
                begin
                    l2 = cnt_w - off_reg - mb_reg;
                    l1_next = mb_reg;
                    end_next = off_reg + mb_reg + ((l2 > mb_reg) ? mb_reg : l2);
                    st_ra = AW'(off_reg + mb_reg - 1'b1);
                    state_next = hms_pkg::ST_MRG_CHK_RD;
                end
            end
            hms_pkg::ST_MRG_CHK_RD:
            begin
                t_next = store_rd_reg;
                st_ra = AW'(off_reg + l1_reg);
                state_next = hms_pkg::ST_MRG_CHK;
            end
            // Skip when the left tail does not order after the right head.
            hms_pkg::ST_MRG_CHK:
            begin
                cmp_a = store_rd_reg;
                cmp_b = t_reg;
                if (!cmp_lt)
                begin
                    off_next = off_reg + (mb_reg << 1);
                    state_next = hms_pkg::ST_MRG_NEXT;
                end
                else
                begin
                    back_next = (l1_reg > (end_reg - off_reg - l1_reg));
                    bi_next = '0;
                    state_next = hms_pkg::ST_MRG_COPY_RD;
                end
            end
            // Copy the shorter run into the buffer.
            hms_pkg::ST_MRG_COPY_RD:
            begin
                if (bi_reg >= (back_reg ? (end_reg - off_reg - l1_reg) : l1_reg))
                begin
                    if (back_reg)
                    begin
                        i_next = off_reg + l1_reg;
                        j_next = end_reg - off_reg - l1_reg;
                        k_next = end_reg;
                    end
                    else
                    begin
                        i_next = '0;
                        j_next = off_reg + l1_reg;
                        k_next = off_reg;
                    end
                    state_next = hms_pkg::ST_MRG_RD;
                end
                else
                begin
                    st_ra = AW'(back_reg ? (off_reg + l1_reg + bi_reg) : (off_reg + bi_reg));
                    state_next = hms_pkg::ST_MRG_COPY_WR;
                end
            end
            hms_pkg::ST_MRG_COPY_WR:
            begin
                bf_we = 1'b1;
                bf_wa = BW'(bi_reg);
                bf_wd = store_rd_reg;
                bi_next = bi_reg + 1'b1;
                state_next = hms_pkg::ST_MRG_COPY_RD;
            end
            // Fetch the two heads (forward) or tails (backward).
            hms_pkg::ST_MRG_RD:
            begin
                if (!back_reg)
                begin
                    if (i_reg >= l1_reg)
                    begin
                        off_next = off_reg + (mb_reg << 1);
                        state_next = hms_pkg::ST_MRG_NEXT;
                    end
                    else if (j_reg >= end_reg)
                    begin
                        bf_ra = BW'(i_reg);
                        state_next = hms_pkg::ST_MRG_TAIL_RD;
                    end
                    else
                    begin
                        st_ra = AW'(j_reg);
                        bf_ra = BW'(i_reg);
                        state_next = hms_pkg::ST_MRG_SEL;
                    end
                end
                else
                begin
                    if (j_reg == '0)
                    begin
                        off_next = off_reg + (mb_reg << 1);
                        state_next = hms_pkg::ST_MRG_NEXT;
                    end
                    else if (i_reg == off_reg)
                    begin
                        bf_ra = BW'(j_reg - 1'b1);
                        state_next = hms_pkg::ST_MRG_TAIL_RD;
                    end
                    else
                    begin
                        st_ra = AW'(i_reg - 1'b1);
                        bf_ra = BW'(j_reg - 1'b1);
                        state_next = hms_pkg::ST_MRG_SEL;
                    end
                end
            end
            hms_pkg::ST_MRG_SEL:
            begin
                st_we = 1'b1;
                if (!back_reg)
                begin
                    cmp_a = store_rd_reg;
                    cmp_b = buf_rd_reg;
                    st_wa = AW'(k_reg);
                    k_next = k_reg + 1'b1;
                    if (cmp_lt)
                    begin
                        st_wd = store_rd_reg;
                        j_next = j_reg + 1'b1;
                    end
                    else
                    begin
                        st_wd = buf_rd_reg;
                        i_next = i_reg + 1'b1;
                    end
                end
                else
                begin
                    cmp_a = buf_rd_reg;
                    cmp_b = store_rd_reg;
                    st_wa = AW'(k_reg - 1'b1);
                    k_next = k_reg - 1'b1;
                    if (cmp_lt)
                    begin
                        st_wd = store_rd_reg;
                        i_next = i_reg - 1'b1;
                    end
                    else
                    begin
                        st_wd = buf_rd_reg;
                        j_next = j_reg - 1'b1;
                    end
                end
                state_next = hms_pkg::ST_MRG_RD;
            end
            // Hold the buffer address so the read stays in place.
            hms_pkg::ST_MRG_TAIL_RD:
            begin
                bf_ra = back_reg ? BW'(j_reg - 1'b1) : BW'(i_reg);
                state_next = hms_pkg::ST_MRG_TAIL_WR;
            end
            // Drain the buffer remainder.
            hms_pkg::ST_MRG_TAIL_WR:
            begin
                st_we = 1'b1;
                st_wd = buf_rd_reg;
                if (!back_reg)
                begin
                    st_wa = AW'(k_reg);
                    k_next = k_reg + 1'b1;
                    i_next = i_reg + 1'b1;
                end
                else
                begin
                    st_wa = AW'(off_reg + j_reg - 1'b1);
                    j_next = j_reg - 1'b1;
                end
                state_next = hms_pkg::ST_MRG_RD;
            end
            // Emit the sorted words.
            hms_pkg::ST_OUT_RD:
            begin
                if (k_reg >= cnt_w)
                begin
                    count_next = '0;
                    drop_next = 1'b0;
                    mid_next = '0;
                    back_next = 1'b0;
                    state_next = hms_pkg::ST_LOAD;
                end
                else
                begin
                    st_ra = AW'(k_reg);
                    state_next = hms_pkg::ST_OUT_WAIT;
                end
            end
            hms_pkg::ST_OUT_WAIT:
            begin
                st_ra = AW'(k_reg);
                state_next = hms_pkg::ST_OUT_HOLD;
            end
            hms_pkg::ST_OUT_HOLD:
            begin
                st_ra = AW'(k_reg);
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_key_next = 32'(store_rd_reg);
                    out_last_next = (k_reg + 1'b1 == cnt_w);
                    out_ovf_next = drop_reg;
                    k_next = k_reg + 1'b1;
                    state_next = hms_pkg::ST_OUT_RD;
                end
            end
            default:
            begin
                state_next = hms_pkg::ST_LOAD;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign sorted_key = out_key_reg;
    assign last_out   = out_last_reg;
    assign overflow   = out_ovf_reg;

    // Checks.
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("element count beyond capacity");
    a_no_load_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg)
        else $error("pending word lost");
    a_clear_after_batch: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == hms_pkg::ST_OUT_RD && state_next == hms_pkg::ST_LOAD
        |=> count_reg == '0 && !drop_reg)
        else $error("batch state not cleared");
endmodule
